>>> design/sol_pkg.sv
// ----------------------------------------------------------------------------
// sol_pkg
// Shared types and codes for the segment offset locator.
// ----------------------------------------------------------------------------
package sol_pkg;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned LenW    = 32;
  localparam int unsigned PosW    = 42;
  localparam int unsigned OffW    = 32;
  localparam int unsigned StatusW = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_BEYOND = 2'd1,
    ST_BEFORE = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // append a segment length
    logic clear;    // empty the table, rewind the pointer
    logic start;    // latch the query position
    logic advance;  // move the pointer one segment forward
    logic finish;   // write an ok result
    logic err;      // write an error result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic q_err;    // query word at the input cannot be located
    logic more;     // pointer must move further
  } stat_t;

endpackage

>>> design/sol_if.sv
// ----------------------------------------------------------------------------
// sol_if
// Valid/ready channels for the input words and the result words.
// ----------------------------------------------------------------------------
interface sol_in_if;
  logic                      valid;
  logic                      ready;
  logic [sol_pkg::ModeW-1:0] mode;
  logic [sol_pkg::LenW-1:0]  seg_length;
  logic [sol_pkg::PosW-1:0]  position;

  modport source (output valid, mode, seg_length, position, input ready);
  modport sink (input valid, mode, seg_length, position, output ready);
endinterface

interface sol_out_if #(
  parameter int unsigned SEG_W = 11
);
  logic                         valid;
  logic                         ready;
  logic [SEG_W-1:0]             segment_number;
  logic [sol_pkg::OffW-1:0]     offset;
  logic [sol_pkg::StatusW-1:0]  status;

  modport source (output valid, segment_number, offset, status, input ready);
  modport sink (input valid, segment_number, offset, status, output ready);
endinterface

>>> design/sol_ram.sv
// ----------------------------------------------------------------------------
// sol_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sol_ram #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sol_dp.sv
// ----------------------------------------------------------------------------
// sol_dp
// Datapath: prefix sum table, segment count, search pointer and result word.
// ----------------------------------------------------------------------------
module sol_dp #(
  parameter int unsigned MAX_SEGMENTS = 1024,
  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1),
  localparam int unsigned AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sol_pkg::cmd_t               cmd_i,
  output sol_pkg::stat_t              stat_o,
  input  logic [sol_pkg::LenW-1:0]    seg_length_i,
  input  logic [sol_pkg::PosW-1:0]    position_i,
  output logic [CntW-1:0]             segment_number_o,
  output logic [sol_pkg::OffW-1:0]    offset_o,
  output logic [sol_pkg::StatusW-1:0] status_o
);

  import sol_pkg::*;

  logic [CntW-1:0]    count_q, count_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [PosW-1:0]    total_q, total_d;
  logic [PosW-1:0]    start_q, start_d;
  logic [PosW-1:0]    pos_q;
  logic [PosW:0]      sum;
  logic [PosW-1:0]    sum_sat;
  logic               full;
  logic               beyond;
  logic               before_start;
  logic [PosW-1:0]    rdata;
  logic [CntW-1:0]    ptr_next;
  logic [PosW-1:0]    diff;
  logic [CntW-1:0]    seg_q;
  logic [OffW-1:0]    off_q;
  status_e            st_q;

  assign full    = (count_q == CntW'(MAX_SEGMENTS));
  assign sum     = {1'b0, total_q} + {{(PosW + 1 - LenW){1'b0}}, seg_length_i};
  assign sum_sat = sum[PosW] ? {PosW{1'b1}} : sum[PosW-1:0];

  // An empty table reads as zero total, so no separate check on the sum is
  // needed beyond the count.
  assign beyond       = (count_q == '0) || (position_i > total_q);
  assign before_start = (position_i <= start_q);

  assign ptr_next = CntW'(ptr_q) + CntW'(1);
  assign stat_o.q_err = beyond || before_start;
  assign stat_o.more  = (ptr_next < count_q) && (rdata < pos_q);

  assign diff = pos_q - start_q;

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    ptr_d   = ptr_q;
    start_d = start_q;
    if (cmd_i.clear) begin
      count_d = '0;
      total_d = '0;
      ptr_d   = '0;
      start_d = '0;
    end else if (cmd_i.load && !full) begin
      count_d = count_q + CntW'(1);
      total_d = sum_sat;
    end else if (cmd_i.advance) begin
      ptr_d   = ptr_q + AW'(1);
      start_d = rdata;
    end
  end

  // The read address follows the next pointer, so the word of the current
  // segment is on the read port in the cycle after.
  sol_ram #(
    .WIDTH (PosW),
    .DEPTH (MAX_SEGMENTS)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && !full),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (sum_sat),
    .raddr_i (ptr_d),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      ptr_q   <= '0;
      start_q <= '0;
    end else begin
      count_q <= count_d;
      total_q <= total_d;
      ptr_q   <= ptr_d;
      start_q <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pos_q <= position_i;
    end
    if (cmd_i.err) begin
      seg_q <= '0;
      off_q <= '0;
      st_q  <= beyond ? ST_BEYOND : ST_BEFORE;
    end else if (cmd_i.finish) begin
      seg_q <= ptr_next;
      off_q <= diff[OffW-1:0];
      st_q  <= ST_OK;
    end
  end

  assign segment_number_o = seg_q;
  assign offset_o         = off_q;
  assign status_o         = st_q;

endmodule

>>> design/sol_ctrl.sv
// ----------------------------------------------------------------------------
// sol_ctrl
// Controller: handshakes, search sequencing and result valid flag.
// ----------------------------------------------------------------------------
module sol_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [sol_pkg::ModeW-1:0] in_mode_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output sol_pkg::cmd_t             cmd_o,
  input  sol_pkg::stat_t            stat_i
);

  import sol_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // The result register must be free (or emptying) before any word is taken,
  // so a query can always deliver its result.
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_mode_i == MODE_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (in_mode_i == MODE_CLEAR) begin
            cmd_o.clear = 1'b1;
          end else if (in_mode_i == MODE_QUERY) begin
            if (stat_i.q_err) begin
              cmd_o.err = 1'b1;
            end else begin
              cmd_o.start = 1'b1;
              state_d     = S_SEARCH;
            end
          end
        end
      end
      S_SEARCH: begin
        if (stat_i.more) begin
          cmd_o.advance = 1'b1;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.err || cmd_o.finish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/segment_offset_locator.sv
// ----------------------------------------------------------------------------
// segment_offset_locator
// Locates the segment and in-segment offset of a global position.
// ----------------------------------------------------------------------------
// Segment lengths are appended one per load word and kept as saturating
// prefix sums in a MAX_SEGMENTS-deep RAM; a clear word empties the table.
// A query word returns one result: the 1-based segment number and offset,
// or status beyond-total or before-current-start with zero fields. An
// accepted query latches its position; the forward-only pointer then
// moves one segment at a time, one RAM read per step, and the result is
// written when it stops. Over a run of nondecreasing queries the pointer
// steps add up to at most the segment count. No word is taken while a
// result waits and is not being taken.
// The table needs no initialization after reset.
// ----------------------------------------------------------------------------
module segment_offset_locator #(
  parameter int unsigned MAX_SEGMENTS = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  sol_in_if.sink    in_i,
  sol_out_if.source out_o
);

  import sol_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);

  cmd_t            cmd;
  stat_t           stat;
  logic [CntW-1:0] seg_num;

  sol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_mode_i   (in_i.mode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  sol_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .seg_length_i     (in_i.seg_length),
    .position_i       (in_i.position),
    .segment_number_o (seg_num),
    .offset_o         (out_o.offset),
    .status_o         (out_o.status)
  );

  assign out_o.segment_number = seg_num;

endmodule

>>> tb/segment_offset_locator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_offset_locator_tb
// Self-checking bench for the segment offset locator.
// ----------------------------------------------------------------------------
// A queue of words filled by the stimulus process feeds a clocked driver; a
// clocked monitor takes result words and compares them with the predictions
// made when each word was accepted. Directed words cover empty tables, zero
// lengths, decreasing and out-of-range queries; random groups of loads and
// nondecreasing queries follow, under three patterns of sender and receiver
// stalls.
// ----------------------------------------------------------------------------
module segment_offset_locator_tb;
  import sol_pkg::*;

  localparam int unsigned MaxSeg     = 1024;
  localparam int unsigned SegW       = 11;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam logic [41:0] SumMax     = 42'h3FF_FFFF_FFFF;

  typedef struct {
    mode_e       mode;
    logic [31:0] len;
    logic [41:0] pos;
  } word_t;

  typedef struct {
    logic [SegW-1:0] seg;
    logic [31:0]     off;
    status_e         st;
  } loc_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sol_in_if                   in_bus ();
  sol_out_if #(.SEG_W(SegW))  out_bus ();

  segment_offset_locator #(
    .MAX_SEGMENTS(MaxSeg)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predicted state of the block.
  logic [41:0] seg_prefix [MaxSeg];
  int unsigned seg_cnt;
  int unsigned cur_seg;

  word_t       word_q [$];
  loc_t        located_q [$];
  word_t       cur_word;
  loc_t        loc_res;
  loc_t        loc_exp;
  int unsigned queued_cnt;
  int unsigned taken_cnt;
  int unsigned fails;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Stimulus-side view of the table, used to aim query positions and to decide when to clear.
  logic [42:0] gen_total;
  logic [42:0] gen_pos;
  int unsigned gen_count;

  function automatic logic [41:0] seg_begin(input int unsigned idx);
    if (idx == 0) begin
      return '0;
    end
    return seg_prefix[idx-1];
  endfunction

  function automatic bit locate_word(input word_t w, output loc_t r);
    logic [42:0] sum;
    logic [41:0] total;
    int unsigned p;
    r.seg = '0;
    r.off = '0;
    r.st  = ST_OK;
    case (w.mode)
      MODE_LOAD: begin
        if (seg_cnt < MaxSeg) begin
          sum = {1'b0, seg_begin(seg_cnt)} + {11'd0, w.len};
          if (sum > {1'b0, SumMax}) begin
            sum = {1'b0, SumMax};
          end
          seg_prefix[seg_cnt] = sum[41:0];
          seg_cnt++;
        end
        return 1'b0;
      end
      MODE_CLEAR: begin
        seg_cnt = 0;
        cur_seg = 0;
        return 1'b0;
      end
      MODE_QUERY: begin
        total = seg_begin(seg_cnt);
        if (seg_cnt == 0 || w.pos > total) begin
          r.st = ST_BEYOND;
          return 1'b1;
        end
        if (w.pos <= seg_begin(cur_seg)) begin
          r.st = ST_BEFORE;
          return 1'b1;
        end
        // Zero-length segments share their end with the one before, so the
        // scan steps over them.
        p = cur_seg;
        while (p + 1 < seg_cnt && seg_prefix[p] < w.pos) begin
          p++;
        end
        cur_seg = p;
        r.seg = SegW'(p + 1);
        r.off = 32'(w.pos - seg_begin(p));
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  // Driver: a word is offered when the channel is free, unless the sender
  // idles this cycle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        if (locate_word(cur_word, loc_res)) begin
          located_q = {located_q, loc_res};
        end
        taken_cnt++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (word_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_word = word_q.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.mode       <= cur_word.mode;
          in_bus.seg_length <= cur_word.len;
          in_bus.position   <= cur_word.pos;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (located_q.size() == 0) begin
          $error("unexpected result word: segment_number %0d offset %0d status %0d",
                 out_bus.segment_number, out_bus.offset, out_bus.status);
          fails++;
        end else begin
          loc_exp = located_q.pop_front();
          if (out_bus.segment_number !== loc_exp.seg) begin
            $error("segment_number: expected %0d, actual %0d", loc_exp.seg,
                   out_bus.segment_number);
            fails++;
          end
          if (out_bus.offset !== loc_exp.off) begin
            $error("offset: expected %0d, actual %0d", loc_exp.off, out_bus.offset);
            fails++;
          end
          if (out_bus.status !== loc_exp.st) begin
            $error("status: expected %0d, actual %0d", loc_exp.st, out_bus.status);
            fails++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_word(input mode_e m, input logic [31:0] len, input logic [41:0] pos);
    word_t w;
    w.mode = m;
    w.len  = len;
    w.pos  = pos;
    word_q = {word_q, w};
    queued_cnt++;
  endtask

  task automatic gen_load(input logic [31:0] len);
    logic [63:0] r;
    r = {$urandom, $urandom};
    push_word(MODE_LOAD, len, r[41:0]);
    if (gen_count < MaxSeg) begin
      gen_total += {11'd0, len};
      gen_count++;
    end
  endtask

  task automatic gen_clear();
    logic [63:0] r;
    r = {$urandom, $urandom};
    push_word(MODE_CLEAR, r[31:0], r[63:22]);
    gen_total = '0;
    gen_pos   = '0;
    gen_count = 0;
  endtask

  task automatic gen_query(input logic [42:0] pos);
    push_word(MODE_QUERY, $urandom, pos[41:0]);
  endtask

  // Waits, with the sender holding back, until every word is taken and every
  // predicted result has come out.
  task automatic drain();
    @(negedge clk_i);
    while (taken_cnt != queued_cnt || located_q.size() != 0 || in_bus.valid) begin
      @(negedge clk_i);
    end
  endtask

  // One group: usually a fresh table, a few loads, then mostly nondecreasing
  // queries with some noise mixed in.
  task automatic random_group(inout int unsigned counted);
    int unsigned n_load;
    int unsigned n_query;
    int unsigned kind;
    bit          big;
    logic [31:0] len;
    logic [63:0] r;
    logic [42:0] pos;
    if ($urandom_range(0, 7) != 0 || gen_count > 900) begin
      gen_clear();
      counted++;
    end
    big    = ($urandom_range(0, 5) == 0);
    n_load = $urandom_range(1, 12);
    for (int i = 0; i < n_load; i++) begin
      len = big ? $urandom : $urandom_range(0, 20);
      gen_load(len);
      counted++;
    end
    n_query = $urandom_range(1, 10);
    for (int i = 0; i < n_query; i++) begin
      kind = $urandom_range(0, 19);
      r    = {$urandom, $urandom};
      if (kind == 0) begin
        push_word(MODE_NONE, r[31:0], r[63:22]);
      end else begin
        counted++;
        if (kind == 1) begin
          gen_query({1'b0, r[41:0]});
        end else if (kind == 2) begin
          gen_query(r[42:0] % (gen_pos + 43'd1));
        end else if (kind == 3) begin
          gen_load(big ? r[31:0] : 32'($urandom_range(0, 20)));
        end else begin
          pos = gen_pos + (big ? {11'd0, r[31:0]} : 43'($urandom_range(0, 8)));
          if (pos > gen_total && $urandom_range(0, 3) != 0) begin
            pos = gen_total;
          end
          gen_query(pos);
          if (pos > gen_pos) begin
            gen_pos = pos;
          end
        end
      end
    end
  endtask

  initial begin
    int unsigned counted;
    in_bus.valid      = 1'b0;
    in_bus.mode       = MODE_NONE;
    in_bus.seg_length = '0;
    in_bus.position   = '0;
    out_bus.ready     = 1'b0;
    seg_cnt       = 0;
    cur_seg       = 0;
    queued_cnt    = 0;
    taken_cnt     = 0;
    fails         = 0;
    cycle_cnt     = 0;
    gen_total     = '0;
    gen_pos       = '0;
    gen_count     = 0;
    send_idle_pct = 17;
    recv_idle_pct = 48;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, unused mode, zero length, full-width length,
    // decreasing and out-of-range positions, then a clear.
    push_word(MODE_QUERY, 32'd0, 42'd1);
    push_word(MODE_QUERY, 32'hFFFF_FFFF, 42'd0);
    push_word(MODE_NONE, 32'hFFFF_FFFF, SumMax);
    push_word(MODE_LOAD, 32'd1, 42'd0);
    push_word(MODE_LOAD, 32'd0, SumMax);
    push_word(MODE_LOAD, 32'd5, 42'd0);
    push_word(MODE_LOAD, 32'hFFFF_FFFF, 42'd0);
    push_word(MODE_QUERY, 32'd0, 42'd0);
    push_word(MODE_QUERY, 32'd0, 42'd1);
    push_word(MODE_QUERY, 32'd0, 42'd2);
    push_word(MODE_QUERY, 32'd0, 42'd1);
    push_word(MODE_QUERY, 32'd0, 42'd6);
    push_word(MODE_QUERY, 32'd0, 42'h1_0000_0005);
    push_word(MODE_QUERY, 32'd0, 42'h1_0000_0006);
    push_word(MODE_QUERY, 32'd0, SumMax);
    push_word(MODE_NONE, 32'h1234_5678, 42'h155_5555_5555);
    push_word(MODE_CLEAR, 32'd0, 42'd0);
    push_word(MODE_QUERY, 32'd0, 42'd1);
    push_word(MODE_LOAD, 32'd3, 42'd0);
    push_word(MODE_QUERY, 32'd0, 42'd3);
    push_word(MODE_QUERY, 32'd0, 42'd3);
    push_word(MODE_CLEAR, 32'd0, 42'd0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 48;
        recv_idle_pct = 17;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      counted = 0;
      while (counted < 190) begin
        random_group(counted);
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (located_q.size() != 0) begin
      $error("%0d predicted results never came out", located_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
